@@ rtl/cfws_pkg.sv @@
package cfws_pkg;

  // Command codes carried by an input transaction.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  // Status codes returned with every result transaction.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]          command;
    logic signed [31:0]  data_value;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0]          status;
    logic signed [31:0]  read_data;
    logic                found;
  } out_item_t;

endpackage

@@ rtl/cfws_mem.sv @@
module cfws_mem import cfws_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  logic signed [31:0]  wr_data,
  input  logic                rd_en,
  input  logic [IW-1:0]       rd_addr,
  output logic signed [31:0]  rd_data
);

  logic signed [31:0] mem_r [DEPTH];
  logic signed [31:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/cfws_seq.sv @@
module cfws_seq import cfws_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  in_item_t            item,
  input  logic                out_free,
  output logic                idle,
  output logic                done,
  output out_item_t           result,
  output logic                mem_we,
  output logic [IW-1:0]       mem_waddr,
  output logic signed [31:0]  mem_wdata,
  output logic                mem_re,
  output logic [IW-1:0]       mem_raddr,
  input  logic signed [31:0]  mem_rdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [IW-1:0]       head_r, head_nxt;
  logic [IW-1:0]       tail_r, tail_nxt;
  logic [IW-1:0]       ptr_r, ptr_nxt;
  logic signed [31:0]  key_r, key_nxt;
  out_item_t           res_r, res_nxt;
  logic [IW-1:0]       head_inc, tail_inc, ptr_inc;

  // Ring increment: wraps from the last slot back to slot zero.
  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] i);
    logic [IW-1:0] r;
    if (i == IW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  assign head_inc = inc_idx(head_r);
  assign tail_inc = inc_idx(tail_r);
  assign ptr_inc  = inc_idx(ptr_r);

  // Sequencer: one memory read and one compare per cycle while scanning.
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    ptr_nxt   = ptr_r;
    key_nxt   = key_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = tail_inc;
    mem_wdata = item.data_value;
    mem_re    = 1'b0;
    mem_raddr = ptr_inc;
    done      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt   = '0;
          key_nxt   = item.data_value;
          state_nxt = S_DONE;
          case (item.command)
            CMD_INSERT: begin
              if (tail_inc == head_r) begin
                res_nxt.status = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                tail_nxt = tail_inc;
              end
            end
            CMD_DELETE: begin
              if (head_r == tail_r) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                head_nxt  = head_inc;
                mem_re    = 1'b1;
                mem_raddr = head_inc;
                state_nxt = S_RD;
              end
            end
            CMD_SEARCH: begin
              if (head_r != tail_r) begin
                mem_re    = 1'b1;
                mem_raddr = head_inc;
                ptr_nxt   = head_inc;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_nxt = '0;
            end
          endcase
        end
      end
      S_RD: begin
        res_nxt.read_data = mem_rdata;
        state_nxt         = S_DONE;
      end
      S_SCAN: begin
        // The read data belongs to the entry at ptr_r.
        if (mem_rdata == key_r) begin
          res_nxt.found = 1'b1;
          state_nxt     = S_DONE;
        end else if (ptr_r == tail_r) begin
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ptr_inc;
          mem_re  = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state is reset; the key, scan pointer and result are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
    ptr_r <= ptr_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  assign idle   = (state_r == S_IDLE);
  assign result = res_r;

endmodule

@@ rtl/circular_fifo_with_search_top.sv @@
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_ready   | in_data  (command, data_value)
// out_    | output    | out_valid/out_ready | out_data (status, read_data, found)
//
// Insert writes its entry and finishes; delete first reads the oldest entry; search
// walks the live entries (at most DEPTH-1) through the single memory read port.
// A result then sits in the output register until it is taken.
// Reset (rst_n low, synchronous) empties the queue; entry contents are not cleared.
// A stalled output holds the sequencer in its final step; in_ready is low until idle.
module circular_fifo_with_search_top import cfws_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                start, out_free, seq_idle, seq_done;
  out_item_t           seq_result;
  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  logic signed [31:0]  mem_wdata, mem_rdata;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r;

  // Input transaction handshake.
  assign in_ready = seq_idle;
  assign start    = in_valid & seq_idle;

  // The output register may be refilled in the cycle it is emptied.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (seq_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (seq_done) begin
      out_data_r <= seq_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cfws_seq #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (in_data),
    .out_free  (out_free),
    .idle      (seq_idle),
    .done      (seq_done),
    .result    (seq_result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  cfws_mem #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule

@@ sim/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cfws_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int RECENT_WORDS = 8;

  // One row of the directed plan; fixed rows carry their own expected result.
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] value;
    bit          rand_value;
    int          count;
    bit          fixed;
    out_item_t   result;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Side information that travels with each offered transaction.
  logic      item_fixed;
  out_item_t item_fixed_result;

  // Ring buffer shadow used for prediction.
  logic [31:0] ring_words [DEPTH];
  int          ring_head;
  int          ring_tail;

  out_item_t   pending_results[$];
  plan_row_t   plan[$];
  logic [31:0] recent_inserts [RECENT_WORDS];
  int          recent_ptr;
  int          error_count;
  int          cycle_count;
  bit          steady;
  bit          long_hold;

  circular_fifo_with_search_top #(.DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Applies one command to the shadow ring and returns the result it should give.
  function automatic out_item_t ring_step(in_item_t item);
    out_item_t res;
    int slot;
    res.status = ST_OK;
    res.read_data = '0;
    res.found = 1'b0;
    case (item.command)
      CMD_INSERT: begin
        slot = (ring_tail + 1) % DEPTH;
        if (slot == ring_head) begin
          res.status = ST_FULL;
        end else begin
          ring_tail = slot;
          ring_words[slot] = item.data_value;
        end
      end
      CMD_DELETE: begin
        if (ring_head == ring_tail) begin
          res.status = ST_EMPTY;
        end else begin
          ring_head = (ring_head + 1) % DEPTH;
          res.read_data = ring_words[ring_head];
        end
      end
      CMD_SEARCH: begin
        // Walk the live entries from oldest to newest.
        slot = ring_head;
        while (slot != ring_tail) begin
          slot = (slot + 1) % DEPTH;
          if (ring_words[slot] == item.data_value) res.found = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Checks each result transaction, then predicts each accepted input transaction.
  always @(posedge clk) begin : scoreboard
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", {30'd0, out_data.status}, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", {30'd0, out_data.status}, {30'd0, want.status});
          if (out_data.read_data !== want.read_data)
            report_mismatch("read_data", out_data.read_data, want.read_data);
          if (out_data.found !== want.found)
            report_mismatch("found", {31'd0, out_data.found}, {31'd0, want.found});
        end
      end
      if (in_valid && in_ready) begin
        want = ring_step(in_data);
        pending_results.push_back(item_fixed ? item_fixed_result : want);
      end
    end
  end

  // Idle stretch length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Data words lean toward extremes and small values so searches can hit.
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      3, 4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Random command mix; insert_pct sets how hard the queue is pushed toward full.
  function automatic in_item_t random_item(int insert_pct);
    in_item_t item;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) item.command = CMD_UNUSED;
    else if (r < 3 + insert_pct) item.command = CMD_INSERT;
    else if (r < 3 + insert_pct + (97 - insert_pct) * 2 / 3) item.command = CMD_DELETE;
    else item.command = CMD_SEARCH;
    item.data_value = random_word();
    if (item.command == CMD_SEARCH && $urandom_range(0, 1))
      item.data_value = recent_inserts[$urandom_range(0, RECENT_WORDS - 1)];
    if (item.command == CMD_INSERT) begin
      recent_inserts[recent_ptr] = item.data_value;
      recent_ptr = (recent_ptr + 1) % RECENT_WORDS;
    end
    return item;
  endfunction

  function automatic plan_row_t typed(logic [1:0] cmd, logic [31:0] value,
                                      logic [1:0] st, logic [31:0] rd, logic fd);
    plan_row_t row;
    row.cmd = cmd;
    row.value = value;
    row.rand_value = 1'b0;
    row.count = 1;
    row.fixed = 1'b1;
    row.result.status = st;
    row.result.read_data = rd;
    row.result.found = fd;
    return row;
  endfunction

  function automatic plan_row_t predicted(logic [1:0] cmd, logic [31:0] value,
                                          bit rand_value, int count);
    plan_row_t row;
    row.cmd = cmd;
    row.value = value;
    row.rand_value = rand_value;
    row.count = count;
    row.fixed = 1'b0;
    row.result = '0;
    return row;
  endfunction

  // Offers one input transaction after an optional gap and waits for acceptance.
  task automatic send_item(in_item_t item, bit fixed, out_item_t fixed_res);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    item_fixed <= fixed;
    item_fixed_result <= fixed_res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Lowers valid and waits until every outstanding result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Result side: ready with random stalls, plus one long hold-off on request.
  initial begin : receiver
    int span;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      span = steady ? 0 : idle_len();
      if (span > 0) begin
        out_ready <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    in_item_t item;
    int pct;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    item_fixed = 1'b0;
    item_fixed_result = '0;
    ring_head = 0;
    ring_tail = 0;
    recent_ptr = 0;
    error_count = 0;
    cycle_count = 0;
    steady = 1'b0;
    long_hold = 1'b0;
    foreach (ring_words[k]) ring_words[k] = '0;
    foreach (recent_inserts[k]) recent_inserts[k] = '0;

    // Directed plan: empty-queue cases, extremes, fill to full, wrap of the tail.
    plan.push_back(typed(CMD_DELETE, 32'h0, ST_EMPTY, 32'h0, 1'b0));
    plan.push_back(typed(CMD_SEARCH, 32'h0, ST_OK, 32'h0, 1'b0));
    plan.push_back(typed(CMD_UNUSED, 32'h0, ST_OK, 32'h0, 1'b0));
    plan.push_back(typed(CMD_INSERT, 32'h8000_0000, ST_OK, 32'h0, 1'b0));
    plan.push_back(typed(CMD_INSERT, 32'h7FFF_FFFF, ST_OK, 32'h0, 1'b0));
    plan.push_back(typed(CMD_INSERT, 32'hFFFF_FFFF, ST_OK, 32'h0, 1'b0));
    plan.push_back(typed(CMD_INSERT, 32'h0, ST_OK, 32'h0, 1'b0));
    plan.push_back(predicted(CMD_INSERT, 32'h0, 1'b1, DEPTH - 5));
    plan.push_back(typed(CMD_INSERT, 32'h1234_5678, ST_FULL, 32'h0, 1'b0));
    plan.push_back(typed(CMD_SEARCH, 32'h7FFF_FFFF, ST_OK, 32'h0, 1'b1));
    plan.push_back(typed(CMD_SEARCH, 32'h0, ST_OK, 32'h0, 1'b1));
    plan.push_back(typed(CMD_DELETE, 32'h0, ST_OK, 32'h8000_0000, 1'b0));
    plan.push_back(typed(CMD_INSERT, 32'h5A5A_5A5A, ST_OK, 32'h0, 1'b0));
    plan.push_back(typed(CMD_SEARCH, 32'h5A5A_5A5A, ST_OK, 32'h0, 1'b1));
    plan.push_back(typed(CMD_DELETE, 32'hFFFF_FFFF, ST_OK, 32'h7FFF_FFFF, 1'b0));
    plan.push_back(predicted(CMD_SEARCH, 32'h8000_0000, 1'b0, 1));
    plan.push_back(typed(CMD_UNUSED, 32'hFFFF_FFFF, ST_OK, 32'h0, 1'b0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      for (int j = 0; j < plan[k].count; j++) begin
        item.command = plan[k].cmd;
        item.data_value = plan[k].rand_value ? random_word() : plan[k].value;
        send_item(item, plan[k].fixed, plan[k].result);
      end
    end

    // Random phases alternate between filling, draining and a balanced mix.
    for (int p = 0; p < PHASES; p++) begin
      steady = (p == 2);
      if (p == 3) long_hold = 1'b1;
      if (p == 5) drain_results();
      pct = (p % 3 == 0) ? 70 : ((p % 3 == 1) ? 25 : 45);
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item(pct), 1'b0, '0);
    end
    steady = 1'b0;

    // Let every result arrive, then allow for a late extra one.
    drain_results();
    repeat (4 * DEPTH) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
